// ----- hw/rtl/bmcsr_pkg.sv -----
// Shared constants, job type and helper for the bitmap to CSR converter.
`timescale 1ns / 1ps

package bmcsr_pkg;

	localparam int LANES      = 8;          // pixels per input byte
	localparam int SIZE_W     = 13;         // matrix_size register width
	localparam int ROW_W      = 12;
	localparam int COL_W      = 12;
	localparam int BYTE_W     = 9;          // byte position within a row
	localparam int BPR_W      = 10;         // bytes per row, up to 512
	localparam int POS_W      = 25;
	localparam int LEN_W      = 13;
	localparam int CNT_W      = 4;          // hits in one byte, 0..8
	localparam int LANE_W     = 3;

	localparam logic [SIZE_W-1:0] MAX_SIZE   = 13'd4096;
	localparam logic [SIZE_W-1:0] RESET_SIZE = 13'd8;
	localparam logic [POS_W-1:0]  POS_MAX    = {POS_W{1'b1}};

	localparam logic KIND_ENTRY   = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Everything the emitter needs to serialize the results of one byte.
	typedef struct packed {
		logic [LANES-1:0]  hit_mask;   // bit k set: lane k (column base+k) is a nonzero
		logic [ROW_W-1:0]  row;
		logic [BYTE_W-1:0] byte_idx;
		logic [POS_W-1:0]  pos_base;   // position of the first entry of this byte
		logic [POS_W-1:0]  row_start;
		logic [LEN_W-1:0]  row_len;    // row length including this byte
		logic              has_sum;    // byte closes its row
		logic              done;       // closed row is the final one
	} job_t;

	// Saturating add of a small count onto a position.
	function automatic logic [POS_W-1:0] pos_add(logic [POS_W-1:0] base, logic [CNT_W-1:0] n);
		logic [POS_W:0] sum;
		sum = {1'b0, base} + {{(POS_W+1-CNT_W){1'b0}}, n};
		pos_add = sum[POS_W] ? POS_MAX : sum[POS_W-1:0];
	endfunction

endpackage

// ----- hw/rtl/bitmap_rows_to_csr.sv -----
// Top level: packed bitmap bytes in, CSR entry and row summary beats out.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// config    in         cfg_write              matrix_size
// pixels    in         in_valid / in_stall    data_byte
// results   out        out_valid / out_stall  kind, row_index, column_index,
//                                             entry_position, row_length,
//                                             matrix_done, last
//
// A byte makes 0 to 9 beats (up to eight entries plus a row summary); the
// emitter sends one beat per cycle while out_stall is low and stalls the
// input while it holds a byte with beats still to send. Eight pixel lanes
// test a whole byte in the accept cycle; the single output register of the
// emitter sets the rate. Reset sets matrix_size to 8 and clears all
// counters; a config write also clears them. out_stall holds the current
// beat and, while the emitter holds a byte, backs up into in_stall.
module bitmap_rows_to_csr (
	input  logic                          clk,
	input  logic                          arst_n,
	// config
	input  logic                          cfg_write,
	input  logic [bmcsr_pkg::SIZE_W-1:0]  matrix_size,
	// pixel bytes
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [7:0]                    data_byte,
	// results
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          kind,
	output logic [bmcsr_pkg::ROW_W-1:0]   row_index,
	output logic [bmcsr_pkg::COL_W-1:0]   column_index,
	output logic [bmcsr_pkg::POS_W-1:0]   entry_position,
	output logic [bmcsr_pkg::LEN_W-1:0]   row_length,
	output logic                          matrix_done,
	output logic                          last
);
	import bmcsr_pkg::*;

	job_t job;
	logic has_results;
	logic emit_ready;
	logic in_fire;

	// a byte is taken whenever the emitter slot is free or frees this cycle
	assign in_stall = !emit_ready;
	assign in_fire  = in_valid && emit_ready;

	// counters, lanes and hit merge
	bmcsr_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_size    (matrix_size),
		.in_fire     (in_fire),
		.data_byte   (data_byte),
		.job         (job),
		.has_results (has_results)
	);

	// serializer with output register; bytes without beats never enter it
	bmcsr_emit u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (in_fire && has_results),
		.job_in         (job),
		.ready          (emit_ready),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.kind           (kind),
		.row_index      (row_index),
		.column_index   (column_index),
		.entry_position (entry_position),
		.row_length     (row_length),
		.matrix_done    (matrix_done),
		.last           (last)
	);

endmodule

// ----- hw/rtl/bmcsr_lane.sv -----
// One pixel lane: flags a set pixel that lies inside the matrix.
`timescale 1ns / 1ps

module bmcsr_lane (
	input  logic                        pixel,
	input  logic [bmcsr_pkg::COL_W-1:0] col,
	input  logic [bmcsr_pkg::SIZE_W-1:0] size,
	output logic                        hit
);
	import bmcsr_pkg::*;

	// padding columns at or past the size are dropped
	assign hit = pixel && ({1'b0, col} < size);

endmodule

// ----- hw/rtl/bmcsr_front.sv -----
// Front end: size register, row counters, pixel lanes and hit merge.
`timescale 1ns / 1ps

module bmcsr_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write,
	input  logic [bmcsr_pkg::SIZE_W-1:0] cfg_size,
	input  logic                         in_fire,
	input  logic [7:0]                   data_byte,
	output bmcsr_pkg::job_t              job,
	output logic                         has_results
);
	import bmcsr_pkg::*;

	logic [SIZE_W-1:0] size_q;
	logic [ROW_W-1:0]  row_q;
	logic [BYTE_W-1:0] bir_q;
	logic [POS_W-1:0]  nc_q;
	logic [POS_W-1:0]  rs_q;
	logic [LEN_W-1:0]  rn_q;

	logic [LANES-1:0]  hits;
	logic [CNT_W-1:0]  cnt;
	logic [SIZE_W-1:0] bpr_sum;
	logic [BPR_W-1:0]  bpr;
	logic [BPR_W-1:0]  bir_inc;
	logic              end_row;
	logic              done;
	logic [POS_W-1:0]  nc_new;
	logic [LEN_W-1:0]  rn_new;
	logic [SIZE_W-1:0] size_eff;

	// clamp written size to 1..MAX_SIZE
	always_comb begin
		if (cfg_size == '0) begin
			size_eff = SIZE_W'(1);
		end else if (cfg_size > MAX_SIZE) begin
			size_eff = MAX_SIZE;
		end else begin
			size_eff = cfg_size;
		end
	end

	genvar k;
	generate
		for (k = 0; k < LANES; k++) begin : g_lane
			bmcsr_lane u_lane (
				.pixel (data_byte[LANES-1-k]),
				.col   ({bir_q, LANE_W'(k)}),
				.size  (size_q),
				.hit   (hits[k])
			);
		end
	endgenerate

	// merge: hit count of the byte
	always_comb begin
		cnt = '0;
		for (int i = 0; i < LANES; i++) begin
			cnt = cnt + CNT_W'(hits[i]);
		end
	end

	// size is at most 4096, so size + 7 still fits the register width
	assign bpr_sum = size_q + SIZE_W'(LANES - 1);
	assign bpr     = bpr_sum[SIZE_W-1:LANE_W];
	assign bir_inc = {1'b0, bir_q} + BPR_W'(1);
	assign end_row = bir_inc >= bpr;
	assign done    = ({1'b0, row_q} + SIZE_W'(1)) >= size_q;
	assign nc_new  = pos_add(nc_q, cnt);
	assign rn_new  = rn_q + LEN_W'(cnt);

	always_comb begin
		job.hit_mask  = hits;
		job.row       = row_q;
		job.byte_idx  = bir_q;
		job.pos_base  = nc_q;
		job.row_start = rs_q;
		job.row_len   = rn_new;
		job.has_sum   = end_row;
		job.done      = done;
	end

	assign has_results = (hits != '0) || end_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= RESET_SIZE;
			row_q  <= '0;
			bir_q  <= '0;
			nc_q   <= '0;
			rs_q   <= '0;
			rn_q   <= '0;
		end else if (cfg_write) begin
			size_q <= size_eff;
			row_q  <= '0;
			bir_q  <= '0;
			nc_q   <= '0;
			rs_q   <= '0;
			rn_q   <= '0;
		end else if (in_fire) begin
			if (end_row && done) begin
				row_q <= '0;
				bir_q <= '0;
				nc_q  <= '0;
				rs_q  <= '0;
				rn_q  <= '0;
			end else if (end_row) begin
				row_q <= row_q + ROW_W'(1);
				bir_q <= '0;
				nc_q  <= nc_new;
				rs_q  <= nc_new;
				rn_q  <= '0;
			end else begin
				bir_q <= bir_inc[BYTE_W-1:0];
				nc_q  <= nc_new;
				rn_q  <= rn_new;
			end
		end
	end

endmodule

// ----- hw/rtl/bmcsr_emit.sv -----
// Emitter: holds one byte job and sends its results one beat per cycle while out_stall is low.
`timescale 1ns / 1ps

module bmcsr_emit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  bmcsr_pkg::job_t               job_in,
	output logic                          ready,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          kind,
	output logic [bmcsr_pkg::ROW_W-1:0]   row_index,
	output logic [bmcsr_pkg::COL_W-1:0]   column_index,
	output logic [bmcsr_pkg::POS_W-1:0]   entry_position,
	output logic [bmcsr_pkg::LEN_W-1:0]   row_length,
	output logic                          matrix_done,
	output logic                          last
);
	import bmcsr_pkg::*;

	job_t              job_q;
	logic              job_valid_q;
	logic [LANES-1:0]  mask_q;
	logic [CNT_W-1:0]  idx_q;

	logic              out_valid_q;
	logic              kind_q;
	logic [ROW_W-1:0]  row_q;
	logic [COL_W-1:0]  col_q;
	logic [POS_W-1:0]  pos_q;
	logic [LEN_W-1:0]  len_q;
	logic              done_q;
	logic              last_q;

	logic              adv;
	logic [LANE_W-1:0] pick;
	logic [LANES-1:0]  mask_next;
	logic              is_entry;
	logic              job_end;

	// lowest set lane first: column order
	always_comb begin
		pick = '0;
		for (int i = LANES - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				pick = LANE_W'(i);
			end
		end
	end

	assign is_entry  = mask_q != '0;
	assign mask_next = mask_q & ~(LANES'(1) << pick);
	assign adv       = !out_valid_q || !out_stall;
	assign job_end   = is_entry ? (mask_next == '0 && !job_q.has_sum) : 1'b1;
	assign ready     = !job_valid_q || (adv && job_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_valid_q <= 1'b0;
		end else if (load) begin
			job_valid_q <= 1'b1;
		end else if (adv && job_end) begin
			job_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_q  <= job_in;
			mask_q <= job_in.hit_mask;
			idx_q  <= '0;
		end else if (adv && job_valid_q && is_entry) begin
			mask_q <= mask_next;
			idx_q  <= idx_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= job_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && job_valid_q) begin
			row_q <= job_q.row;
			if (is_entry) begin
				kind_q <= KIND_ENTRY;
				col_q  <= {job_q.byte_idx, pick};
				pos_q  <= pos_add(job_q.pos_base, idx_q);
				len_q  <= '0;
				done_q <= 1'b0;
				last_q <= job_end;
			end else begin
				kind_q <= KIND_SUMMARY;
				col_q  <= '0;
				pos_q  <= job_q.row_start;
				len_q  <= job_q.row_len;
				done_q <= job_q.done;
				last_q <= 1'b1;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign row_index      = row_q;
	assign column_index   = col_q;
	assign entry_position = pos_q;
	assign row_length     = len_q;
	assign matrix_done    = done_q;
	assign last           = last_q;

	// a new job only lands in a free slot
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> ready)
		else $error("job loaded while slot busy");

	// an emptied entry mask is only left behind for a pending summary
	a_mask_sum: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_q && mask_q == '0 |-> job_q.has_sum)
		else $error("job held with nothing to send");

	// summary beats always close their byte
	a_sum_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == KIND_SUMMARY |-> last_q)
		else $error("summary not marked last");

	// matrix end only rides on a summary
	a_done_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> kind_q == KIND_SUMMARY)
		else $error("matrix_done on an entry beat");

endmodule

// ----- tb/csr_result_check.sv -----
// Result checker: predicts CSR beats from accepted pixel bytes and compares them.
`timescale 1ns / 1ps

module csr_result_check
	import bmcsr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write,
	input  logic [SIZE_W-1:0] matrix_size,
	input  logic              in_valid,
	input  logic              in_stall,
	input  logic [7:0]        data_byte,
	input  logic              out_valid,
	input  logic              out_stall,
	input  logic              kind,
	input  logic [ROW_W-1:0]  row_index,
	input  logic [COL_W-1:0]  column_index,
	input  logic [POS_W-1:0]  entry_position,
	input  logic [LEN_W-1:0]  row_length,
	input  logic              matrix_done,
	input  logic              last,
	output int                errors,
	output int                pending
);

	typedef struct packed {
		logic             kind;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
		logic [POS_W-1:0] pos;
		logic [LEN_W-1:0] len;
		logic             done;
		logic             last;
	} csr_beat_t;

	csr_beat_t         expected_beats[$];

	// shadow of the converter state
	logic [SIZE_W-1:0] dim_reg;
	logic [ROW_W-1:0]  cur_row;
	int                byte_pos;   // wide on purpose: reaches 512 before the row closes
	logic [POS_W-1:0]  nz_pos;
	logic [POS_W-1:0]  row_ptr;
	logic [LEN_W-1:0]  row_nz;
	int                bad;

	task automatic clear_walk();
		cur_row  = '0;
		byte_pos = 0;
		nz_pos   = '0;
		row_ptr  = '0;
		row_nz   = '0;
	endtask

	// One pixel byte: entries for set pixels inside the matrix, then the
	// row summary when the byte closes its row.
	task automatic convert_byte(input logic [7:0] pixels);
		csr_beat_t made [0:LANES];
		int        n;
		int        dim;
		int        col;
		int        k;
		n   = 0;
		dim = int'(dim_reg);
		if (dim < 1) dim = 1;
		if (dim > int'(MAX_SIZE)) dim = int'(MAX_SIZE);
		for (k = 0; k < LANES; k++) begin
			col = byte_pos * LANES + k;
			if (col < dim && pixels[7-k]) begin
				made[n]      = '0;
				made[n].kind = KIND_ENTRY;
				made[n].row  = cur_row;
				made[n].col  = COL_W'(col);
				made[n].pos  = nz_pos;
				n++;
				if (nz_pos != POS_MAX) nz_pos++;
				row_nz++;
			end
		end
		byte_pos++;
		if (byte_pos >= (dim + 7) / 8) begin
			made[n]      = '0;
			made[n].kind = KIND_SUMMARY;
			made[n].row  = cur_row;
			made[n].pos  = row_ptr;
			made[n].len  = row_nz;
			made[n].done = (int'(cur_row) + 1 >= dim);
			if (made[n].done) begin
				clear_walk();
			end else begin
				cur_row++;
				byte_pos = 0;
				row_ptr  = nz_pos;
				row_nz   = '0;
			end
			n++;
		end
		if (n > 0) made[n-1].last = 1'b1;
		for (k = 0; k < n; k++) expected_beats.push_back(made[k]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		csr_beat_t got;
		csr_beat_t want;
		if (!arst_n) begin
			dim_reg = RESET_SIZE;
			clear_walk();
			expected_beats.delete();
			bad     = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			if (cfg_write) begin
				dim_reg = matrix_size;
				clear_walk();
			end
			if (in_valid && !in_stall) convert_byte(data_byte);
			if (out_valid && !out_stall) begin
				got = {kind, row_index, column_index, entry_position,
					row_length, matrix_done, last};
				if (expected_beats.size() == 0) begin
					if (bad < 10)
						$display("%0t csr beat with nothing expected: kind=%0d row=%0d col=%0d",
							$realtime, got.kind, got.row, got.col);
					bad++;
				end else begin
					want = expected_beats.pop_front();
					if (got !== want) begin
						if (bad < 10) begin
							$display("%0t csr beat mismatch", $realtime);
							$display("  expected kind=%0d row=%0d col=%0d pos=%0d len=%0d done=%0d last=%0d",
								want.kind, want.row, want.col, want.pos, want.len, want.done,
								want.last);
							$display("  actual   kind=%0d row=%0d col=%0d pos=%0d len=%0d done=%0d last=%0d",
								got.kind, got.row, got.col, got.pos, got.len, got.done,
								got.last);
						end
						bad++;
					end
				end
			end
			errors  <= bad;
			pending <= expected_beats.size();
		end
	end

endmodule

// ----- tb/tb_bitmap_rows_to_csr.sv -----
// Testbench top: drives pixel bytes and size writes, paces the result side, gives the verdict.
`timescale 1ns / 1ps

module tb_bitmap_rows_to_csr;
	import bmcsr_pkg::*;

	localparam int TOTAL_BYTES = 280;     // pixel bytes over the whole run
	localparam int HOLD_CYCLES = 150;     // long result-side hold-off
	localparam int SETTLE      = 20;      // covers a byte in flight that makes no beat
	localparam int CYCLE_LIMIT = 400000;  // many times the slowest legal run

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              cfg_write   = 1'b0;
	logic [SIZE_W-1:0] matrix_size = RESET_SIZE;
	logic              in_valid    = 1'b0;
	logic              in_stall;
	logic [7:0]        data_byte   = 8'h00;
	logic              out_valid;
	logic              out_stall   = 1'b0;
	logic              kind;
	logic [ROW_W-1:0]  row_index;
	logic [COL_W-1:0]  column_index;
	logic [POS_W-1:0]  entry_position;
	logic [LEN_W-1:0]  row_length;
	logic              matrix_done;
	logic              last;

	int                errors;
	int                pending;
	int                cycles;
	int                fed = 0;            // pixel beats offered so far

	// pacing knobs for the pixel sender and the result receiver
	bit                gappy      = 1'b1;  // sender inserts idle bursts
	int                stall_odds = 4;     // receiver starts a stall burst at odds of 1 in stall_odds, 0 = never
	bit                hold_out   = 1'b0;  // request one long receiver hold-off

	bitmap_rows_to_csr dut (.*);

	csr_result_check mon (.*);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run limit: anything that hangs the handshakes ends here.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL bitmap_rows_to_csr");
		$finish;
	end

	// Result receiver. Short random stall bursts, or one long hold-off when
	// asked; the hold is counted here so the sender keeps offering bytes and
	// the converter backs up into in_stall.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_out) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_out = 1'b0;
				out_stall <= 1'b0;
			end else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 4)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Pixel densities: empty, full, one pixel, or anything.
	function automatic logic [7:0] pick_pixels();
		case ($urandom_range(0, 5))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'(1 << $urandom_range(0, 7));
			default: return 8'($urandom);
		endcase
	endfunction

	// Offer one pixel beat and hold it until accepted. valid stays high into
	// the next feed unless an idle burst follows.
	task automatic feed(input logic [7:0] pixels);
		data_byte <= pixels;
		in_valid  <= 1'b1;
		fed++;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (gappy && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	// Stop sending until every predicted beat is back, then let a byte
	// that makes no beat clear the pipe.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Size write; only called after drain(), so the converter is idle.
	task automatic set_size(input logic [SIZE_W-1:0] value);
		cfg_write   <= 1'b1;
		matrix_size <= value;
		@(posedge clk);
		cfg_write   <= 1'b0;
	endtask

	initial begin
		int                span;
		int                dim;
		int                pick;
		int                i;
		logic [SIZE_W-1:0] sz;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset size of 8: one byte per row. Eight rows close the matrix,
		// the ninth byte checks that the counters wrapped back to row 0.
		feed(8'h00);
		feed(8'hFF);
		feed(8'h80);
		feed(8'h01);
		feed(8'hAA);
		feed(8'h55);
		feed(8'h7E);
		feed(8'h81);
		feed(8'hFF);
		drain();

		// Size 0 behaves as 1: only the leftmost pixel counts, every byte
		// is a whole matrix.
		set_size('0);
		feed(8'hFF);
		feed(8'h7F);
		feed(8'h80);
		drain();

		// Size 13: two bytes per row, low three bits of the second byte are
		// padding. A row of padding only gives an empty summary. The write
		// also clears the row counters.
		set_size(13'd13);
		feed(8'hFF);
		feed(8'hFF);
		feed(8'h00);
		feed(8'h07);
		feed(8'h80);
		drain();      // sender pause in the middle of a row
		feed(8'h08);
		drain();

		// All-ones size clamps to the maximum: a row there is 512 bytes, so
		// only its opening stretch goes out; the next write drops the rest.
		set_size('1);
		for (i = 0; i < 12; i++) begin
			if (i == 0)
				feed(8'h80);
			else
				feed(pick_pixels());
		end
		drain();
		set_size(MAX_SIZE);
		feed(8'hFF);
		feed(8'h01);
		drain();

		// Long receiver hold-off while the sender keeps pushing dense bytes.
		set_size(RESET_SIZE);
		stall_odds = 0;
		hold_out   = 1'b1;
		for (i = 0; i < 40; i++) feed(pick_pixels());

		// Random phases. Each writes a new size while idle; small sizes get
		// one or two whole matrices, sometimes with a stray partial tail,
		// large ones only a short stretch since the write clears the state.
		while (fed < TOTAL_BYTES) begin
			drain();
			if (fed > TOTAL_BYTES - 60) begin
				// closing stretch without any idling
				gappy      = 1'b0;
				stall_odds = 0;
			end else begin
				gappy      = ($urandom_range(0, 3) != 0);
				stall_odds = ($urandom_range(0, 3) == 0) ? 0 : 4;
			end
			pick = $urandom_range(0, 9);
			if (pick == 0)
				sz = '0;
			else if (pick == 1)
				sz = SIZE_W'($urandom_range(4097, 8191));
			else if (pick == 2)
				sz = SIZE_W'($urandom_range(25, 4096));
			else
				sz = SIZE_W'($urandom_range(1, 24));
			set_size(sz);
			dim = (sz == 0) ? 1 : ((sz > MAX_SIZE) ? int'(MAX_SIZE) : int'(sz));
			if (dim > 24) begin
				span = $urandom_range(1, 24);
			end else begin
				span = dim * ((dim + 7) / 8) * $urandom_range(1, 2);
				if ($urandom_range(0, 3) == 0) span += $urandom_range(1, 5);
			end
			for (i = 0; i < span; i++) begin
				feed(pick_pixels());
				if (gappy && $urandom_range(0, 99) == 0) drain();
			end
		end

		drain();
		if (errors == 0 && pending == 0) begin
			$display("PASS bitmap_rows_to_csr");
		end else begin
			$display("FAIL bitmap_rows_to_csr");
		end
		$finish;
	end

endmodule
